// ===== hw/rtl/hfp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HTTP header field parser package
// Shared constants, types and name tables of the header field parser.
// ----------------------------------------------------------------------------
package hfp_pkg;

	localparam int BYTE_W       = 8;
	localparam int POS_W        = 16;
	localparam int LEN_W        = 32;
	localparam int PHASE_W      = 3;
	localparam int KEY_CNT_W    = 4;
	localparam int POS_BITS_DEF = 16;
	localparam int LEN_BITS_DEF = 32;

	localparam int HOST_LEN = 4;
	localparam int CLEN_LEN = 14;

	localparam logic [BYTE_W-1:0] CH_COLON = 8'h3A;
	localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
	localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
	localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
	localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;

	localparam logic [PHASE_W-1:0] PHC_KEY   = 3'd0;
	localparam logic [PHASE_W-1:0] PHC_COLON = 3'd1;
	localparam logic [PHASE_W-1:0] PHC_VALUE = 3'd2;
	localparam logic [PHASE_W-1:0] PHC_VEND  = 3'd3;
	localparam logic [PHASE_W-1:0] PHC_END   = 3'd4;

	typedef enum logic [4:0] {
		PH_KEY   = 5'b00001,
		PH_COLON = 5'b00010,
		PH_VALUE = 5'b00100,
		PH_VEND  = 5'b01000,
		PH_END   = 5'b10000
	} phase_t;

	typedef struct packed {
		logic [PHASE_W-1:0] phase;
		logic               host_seen;
		logic [POS_W-1:0]   host_start;
		logic [POS_W-1:0]   host_length;
		logic               length_seen;
		logic [LEN_W-1:0]   body_length;
		logic               length_error;
	} result_t;

	function automatic logic [PHASE_W-1:0] phase_code(input phase_t ph);
		logic [PHASE_W-1:0] code;
		unique case (ph)
			PH_KEY:   code = PHC_KEY;
			PH_COLON: code = PHC_COLON;
			PH_VALUE: code = PHC_VALUE;
			PH_VEND:  code = PHC_VEND;
			PH_END:   code = PHC_END;
			default:  code = PHC_KEY;
		endcase
		return code;
	endfunction

	function automatic logic [BYTE_W-1:0] host_char(input logic [1:0] idx);
		logic [BYTE_W-1:0] c;
		unique case (idx)
			2'd0:    c = "H";
			2'd1:    c = "o";
			2'd2:    c = "s";
			2'd3:    c = "t";
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	function automatic logic [BYTE_W-1:0] clen_char(input logic [KEY_CNT_W-1:0] idx);
		logic [BYTE_W-1:0] c;
		unique case (idx)
			4'd0:    c = "C";
			4'd1:    c = "o";
			4'd2:    c = "n";
			4'd3:    c = "t";
			4'd4:    c = "e";
			4'd5:    c = "n";
			4'd6:    c = "t";
			4'd7:    c = "-";
			4'd8:    c = "L";
			4'd9:    c = "e";
			4'd10:   c = "n";
			4'd11:   c = "g";
			4'd12:   c = "t";
			4'd13:   c = "h";
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

// ===== hw/rtl/hfp_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Header byte channel
// Carries one header byte and its absolute position per item.
// ----------------------------------------------------------------------------
interface hfp_in_if;
	logic                          valid;
	logic                          ready;
	logic [hfp_pkg::BYTE_W-1:0]    byte_req;
	logic [hfp_pkg::POS_W-1:0]     position;

	modport source (output valid, output byte_req, output position, input ready);
	modport sink (input valid, input byte_req, input position, output ready);
endinterface

// ===== hw/rtl/hfp_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Parser result channel
// Carries the parser state after each header byte, one item per byte.
// ----------------------------------------------------------------------------
interface hfp_out_if;
	logic                          valid;
	logic                          ready;
	logic [hfp_pkg::PHASE_W-1:0]   phase;
	logic                          host_seen;
	logic [hfp_pkg::POS_W-1:0]     host_start;
	logic [hfp_pkg::POS_W-1:0]     host_length;
	logic                          length_seen;
	logic [hfp_pkg::LEN_W-1:0]     body_length;
	logic                          length_error;

	modport source (output valid, output phase, output host_seen, output host_start,
		output host_length, output length_seen, output body_length,
		output length_error, input ready);
	modport sink (input valid, input phase, input host_seen, input host_start,
		input host_length, input length_seen, input body_length,
		input length_error, output ready);
endinterface

// ===== hw/rtl/http_header_field_parser_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HTTP header field parser unit
// Tracks header fields byte by byte and reports Host and Content-Length.
// A byte item passes through the input register and the result buffer before its result item leaves.
// Throughput: one byte item per cycle while the result buffer is not full; each accepted byte updates the parser state.
// Two result slots and the input register absorb a stalled result channel.
// Reset clears the parser state and all valid flags, asynchronously.
// ----------------------------------------------------------------------------
module http_header_field_parser_unit #(
	parameter int POS_BITS = hfp_pkg::POS_BITS_DEF,
	parameter int LEN_BITS = hfp_pkg::LEN_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	hfp_in_if.sink     hdr,
	hfp_out_if.source  res
);

	logic                       byte_valid_s1;
	logic [hfp_pkg::BYTE_W-1:0] byte_s1;
	logic [hfp_pkg::POS_W-1:0]  pos_s1;
	logic                       buf_full;
	logic                       advance;
	hfp_pkg::result_t           step_result;
	hfp_pkg::result_t           out_result;

	assign advance   = byte_valid_s1 && !buf_full;
	assign hdr.ready = !byte_valid_s1 || !buf_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_valid_s1 <= 1'b0;
		end else if (hdr.ready) begin
			byte_valid_s1 <= hdr.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (hdr.ready && hdr.valid) begin
			byte_s1 <= hdr.byte_req;
			pos_s1  <= hdr.position;
		end
	end

	hfp_core #(
		.POS_BITS (POS_BITS),
		.LEN_BITS (LEN_BITS)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (advance),
		.ch       (byte_s1),
		.position (pos_s1),
		.result   (step_result)
	);

	hfp_obuf u_obuf (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (advance),
		.wdata  (step_result),
		.pop    (res.valid && res.ready),
		.full   (buf_full),
		.valid  (res.valid),
		.rdata  (out_result)
	);

	assign res.phase        = out_result.phase;
	assign res.host_seen    = out_result.host_seen;
	assign res.host_start   = out_result.host_start;
	assign res.host_length  = out_result.host_length;
	assign res.length_seen  = out_result.length_seen;
	assign res.body_length  = out_result.body_length;
	assign res.length_error = out_result.length_error;

endmodule

// ===== hw/rtl/hfp_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Header field parser core
// Holds the parser state and updates it by one header byte when stepped.
// ----------------------------------------------------------------------------
module hfp_core #(
	parameter int POS_BITS = hfp_pkg::POS_BITS_DEF,
	parameter int LEN_BITS = hfp_pkg::LEN_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       step,
	input  logic [hfp_pkg::BYTE_W-1:0] ch,
	input  logic [hfp_pkg::POS_W-1:0]  position,
	output hfp_pkg::result_t           result
);

	localparam int ACC_W = LEN_BITS + 4;
	localparam int KW    = hfp_pkg::KEY_CNT_W;

	hfp_pkg::phase_t       phase_q, phase_d;
	logic [KW-1:0]         key_count_q, key_count_d;
	logic                  host_alive_q, host_alive_d;
	logic                  clen_alive_q, clen_alive_d;
	logic [POS_BITS-1:0]   value_offset_q, value_offset_d;
	logic [POS_BITS-1:0]   value_size_q, value_size_d;
	logic [LEN_BITS-1:0]   digit_acc_q, digit_acc_d;
	logic                  dig_run_q, dig_run_d;
	logic                  dig_any_q, dig_any_d;
	logic                  dig_ovf_q, dig_ovf_d;
	logic [2:0][7:0]       recent_q, recent_d;
	logic                  host_seen_q, host_seen_d;
	logic [POS_BITS-1:0]   host_start_q, host_start_d;
	logic [POS_BITS-1:0]   host_len_q, host_len_d;
	logic                  len_seen_q, len_seen_d;
	logic                  len_error_q, len_error_d;
	logic [LEN_BITS-1:0]   content_q, content_d;

	logic [POS_BITS-1:0]   pos;
	logic [KW-1:0]         kc_in, kc_k;
	logic                  ha_in, ca_in, ha_k, ca_k;
	logic [LEN_BITS-1:0]   acc_in, acc_v;
	logic                  run_in, any_in, ovf_in;
	logic                  run_v, any_v, ovf_v;
	logic                  is_digit;
	logic [3:0]            digit;
	logic [ACC_W-1:0]      prod;
	logic                  crlf;

	assign pos      = POS_BITS'(position);
	assign crlf     = (ch == hfp_pkg::CH_LF) && (recent_q[0] == hfp_pkg::CH_CR);
	assign is_digit = (ch >= hfp_pkg::CH_ZERO) && (ch <= hfp_pkg::CH_NINE);
	assign digit    = 4'(ch - hfp_pkg::CH_ZERO);

	// A new key starts from a clean match after a finished field.
	always_comb begin
		if (phase_q == hfp_pkg::PH_VEND) begin
			kc_in = '0;
			ha_in = 1'b1;
			ca_in = 1'b1;
		end else begin
			kc_in = key_count_q;
			ha_in = host_alive_q;
			ca_in = clen_alive_q;
		end
		ha_k = ha_in && (kc_in < KW'(hfp_pkg::HOST_LEN))
			&& (ch == hfp_pkg::host_char(kc_in[1:0]));
		ca_k = ca_in && (kc_in < KW'(hfp_pkg::CLEN_LEN))
			&& (ch == hfp_pkg::clen_char(kc_in));
		kc_k = (kc_in == '1) ? kc_in : kc_in + 1'b1;
	end

	// The first value byte starts a fresh digit run.
	always_comb begin
		if (phase_q == hfp_pkg::PH_COLON) begin
			acc_in = '0;
			run_in = 1'b1;
			any_in = 1'b0;
			ovf_in = 1'b0;
		end else begin
			acc_in = digit_acc_q;
			run_in = dig_run_q;
			any_in = dig_any_q;
			ovf_in = dig_ovf_q;
		end
		prod  = (ACC_W'(acc_in) << 3) + (ACC_W'(acc_in) << 1) + ACC_W'(digit);
		acc_v = acc_in;
		run_v = run_in;
		any_v = any_in;
		ovf_v = ovf_in;
		if (run_in && is_digit) begin
			any_v = 1'b1;
			if (|prod[ACC_W-1:LEN_BITS]) begin
				ovf_v = 1'b1;
			end else begin
				acc_v = prod[LEN_BITS-1:0];
			end
		end else begin
			run_v = 1'b0;
		end
	end

	always_comb begin
		phase_d        = phase_q;
		key_count_d    = key_count_q;
		host_alive_d   = host_alive_q;
		clen_alive_d   = clen_alive_q;
		value_offset_d = value_offset_q;
		value_size_d   = value_size_q;
		digit_acc_d    = digit_acc_q;
		dig_run_d      = dig_run_q;
		dig_any_d      = dig_any_q;
		dig_ovf_d      = dig_ovf_q;
		recent_d       = recent_q;
		host_seen_d    = host_seen_q;
		host_start_d   = host_start_q;
		host_len_d     = host_len_q;
		len_seen_d     = len_seen_q;
		len_error_d    = len_error_q;
		content_d      = content_q;
		if (phase_q != hfp_pkg::PH_END) begin
			unique case (phase_q)
				hfp_pkg::PH_KEY: begin
					if (ch == hfp_pkg::CH_COLON) begin
						host_alive_d = host_alive_q
							&& (key_count_q == KW'(hfp_pkg::HOST_LEN));
						clen_alive_d = clen_alive_q
							&& (key_count_q == KW'(hfp_pkg::CLEN_LEN));
						phase_d = hfp_pkg::PH_COLON;
					end else begin
						host_alive_d = ha_k;
						clen_alive_d = ca_k;
						key_count_d  = kc_k;
					end
				end
				hfp_pkg::PH_COLON: begin
					if (ch != hfp_pkg::CH_SPACE) begin
						phase_d        = hfp_pkg::PH_VALUE;
						value_offset_d = pos;
						digit_acc_d    = acc_v;
						dig_run_d      = run_v;
						dig_any_d      = any_v;
						dig_ovf_d      = ovf_v;
					end
				end
				hfp_pkg::PH_VALUE: begin
					if (crlf) begin
						value_size_d = pos - value_offset_q - 1'b1;
						phase_d      = hfp_pkg::PH_VEND;
					end else begin
						digit_acc_d = acc_v;
						dig_run_d   = run_v;
						dig_any_d   = any_v;
						dig_ovf_d   = ovf_v;
					end
				end
				hfp_pkg::PH_VEND: begin
					if (host_alive_q) begin
						host_seen_d  = 1'b1;
						host_start_d = value_offset_q;
						host_len_d   = value_size_q;
					end else if (clen_alive_q) begin
						if (dig_any_q && !dig_ovf_q) begin
							len_seen_d = 1'b1;
							content_d  = digit_acc_q;
						end else begin
							len_error_d = 1'b1;
						end
					end
					phase_d      = hfp_pkg::PH_KEY;
					host_alive_d = ha_k;
					clen_alive_d = ca_k;
					key_count_d  = kc_k;
				end
				default: begin
					phase_d = phase_q;
				end
			endcase
			if (crlf && (recent_q[1] == hfp_pkg::CH_LF) && (recent_q[2] == hfp_pkg::CH_CR)) begin
				phase_d = hfp_pkg::PH_END;
			end
			recent_d = {recent_q[1], recent_q[0], ch};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= hfp_pkg::PH_KEY;
			key_count_q    <= '0;
			host_alive_q   <= 1'b1;
			clen_alive_q   <= 1'b1;
			value_offset_q <= '0;
			value_size_q   <= '0;
			digit_acc_q    <= '0;
			dig_run_q      <= 1'b0;
			dig_any_q      <= 1'b0;
			dig_ovf_q      <= 1'b0;
			recent_q       <= '0;
			host_seen_q    <= 1'b0;
			host_start_q   <= '0;
			host_len_q     <= '0;
			len_seen_q     <= 1'b0;
			len_error_q    <= 1'b0;
			content_q      <= '0;
		end else if (step) begin
			phase_q        <= phase_d;
			key_count_q    <= key_count_d;
			host_alive_q   <= host_alive_d;
			clen_alive_q   <= clen_alive_d;
			value_offset_q <= value_offset_d;
			value_size_q   <= value_size_d;
			digit_acc_q    <= digit_acc_d;
			dig_run_q      <= dig_run_d;
			dig_any_q      <= dig_any_d;
			dig_ovf_q      <= dig_ovf_d;
			recent_q       <= recent_d;
			host_seen_q    <= host_seen_d;
			host_start_q   <= host_start_d;
			host_len_q     <= host_len_d;
			len_seen_q     <= len_seen_d;
			len_error_q    <= len_error_d;
			content_q      <= content_d;
		end
	end

	always_comb begin
		result.phase        = hfp_pkg::phase_code(phase_d);
		result.host_seen    = host_seen_d;
		result.host_start   = hfp_pkg::POS_W'(host_start_d);
		result.host_length  = hfp_pkg::POS_W'(host_len_d);
		result.length_seen  = len_seen_d;
		result.body_length  = hfp_pkg::LEN_W'(content_d);
		result.length_error = len_error_d;
	end

	a_end_holds: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == hfp_pkg::PH_END |=> phase_q == hfp_pkg::PH_END)
		else $error("Parser left the finished phase.");

	a_host_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		host_seen_q |=> host_seen_q)
		else $error("Host seen flag was cleared.");

	a_error_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		len_error_q |=> len_error_q)
		else $error("Content length error flag was cleared.");

endmodule

// ===== hw/rtl/hfp_obuf.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Result buffer
// Two-entry queue that holds results while the result channel stalls.
// ----------------------------------------------------------------------------
module hfp_obuf (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  hfp_pkg::result_t wdata,
	input  logic             pop,
	output logic             full,
	output logic             valid,
	output hfp_pkg::result_t rdata
);

	hfp_pkg::result_t entry_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       count_q;

	assign full  = (count_q == 2'd2);
	assign valid = (count_q != 2'd0);
	assign rdata = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != 2'd3)
		else $error("Result buffer count out of range.");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (!full || pop))
		else $error("Result written into a full buffer.");

	a_pop_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !push) |=> count_q == $past(count_q) - 2'd1)
		else $error("Result buffer count did not drop after a read.");

endmodule

// ===== tb/http_header_field_parser_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HTTP header field parser unit testbench
// Streams header bytes at consecutive positions into the parser, predicts the
// parser state after every byte and compares each result item field by field.
// A short directed header comes first. Random fields follow, most of them
// with a correct Host or Content-Length key and the rest noise and broken
// fields. The stream ends with a blank line, and a few bytes follow it.
// Both sides idle at random, and the result side once stalls for a long time.
// ----------------------------------------------------------------------------
module http_header_field_parser_unit_tb;

	localparam int IDLE_LIMIT = 1000;
	localparam int RANDOM_ITEMS = 540;
	localparam string HOST_KEY = "Host";
	localparam string CLEN_KEY = "Content-Length";

	class header_tracker;
		logic [hfp_pkg::PHASE_W-1:0] ph = hfp_pkg::PHC_KEY;
		bit started = 0;
		logic [15:0] kcnt = '0;
		bit host_ok = 1;
		bit clen_ok = 1;
		logic [hfp_pkg::POS_W-1:0] voff = '0;
		logic [hfp_pkg::POS_W-1:0] vsize = '0;
		logic [hfp_pkg::LEN_W-1:0] digits = '0;
		bit digit_run = 0;
		bit digit_any = 0;
		bit digit_ovf = 0;
		logic [hfp_pkg::BYTE_W-1:0] recent [3] = '{default: '0};
		bit host_seen = 0;
		logic [hfp_pkg::POS_W-1:0] host_start = '0;
		logic [hfp_pkg::POS_W-1:0] host_len = '0;
		bit clen_seen = 0;
		logic [hfp_pkg::LEN_W-1:0] clen_value = '0;
		bit clen_err = 0;
		hfp_pkg::result_t expected_states [$];
		int mismatches = 0;

		function void key_restart();
			kcnt = '0;
			host_ok = 1;
			clen_ok = 1;
		endfunction

		function void key_byte(logic [hfp_pkg::BYTE_W-1:0] ch);
			if (!(kcnt < hfp_pkg::HOST_LEN && ch == HOST_KEY[kcnt]))
				host_ok = 0;
			if (!(kcnt < hfp_pkg::CLEN_LEN && ch == CLEN_KEY[kcnt]))
				clen_ok = 0;
			if (kcnt != 16'hFFFF)
				kcnt++;
		endfunction

		function void value_byte(logic [hfp_pkg::BYTE_W-1:0] ch);
			logic [35:0] wide;
			if (digit_run && ch >= hfp_pkg::CH_ZERO && ch <= hfp_pkg::CH_NINE) begin
				digit_any = 1;
				wide = {4'b0, digits} * 36'd10 + 36'(ch - hfp_pkg::CH_ZERO);
				if (wide > 36'hFFFF_FFFF)
					digit_ovf = 1;
				else
					digits = wide[31:0];
			end else begin
				digit_run = 0;
			end
		endfunction

		function void note_byte(logic [hfp_pkg::BYTE_W-1:0] ch,
			logic [hfp_pkg::POS_W-1:0] pos);
			hfp_pkg::result_t want;
			if (ph != hfp_pkg::PHC_END) begin
				if (!started) begin
					started = 1;
					ph = hfp_pkg::PHC_KEY;
					key_restart();
				end
				case (ph)
					hfp_pkg::PHC_KEY: begin
						if (ch == hfp_pkg::CH_COLON) begin
							host_ok = host_ok && kcnt == hfp_pkg::HOST_LEN;
							clen_ok = clen_ok && kcnt == hfp_pkg::CLEN_LEN;
							ph = hfp_pkg::PHC_COLON;
						end else begin
							key_byte(ch);
						end
					end
					hfp_pkg::PHC_COLON: begin
						if (ch != hfp_pkg::CH_SPACE) begin
							ph = hfp_pkg::PHC_VALUE;
							voff = pos;
							digits = '0;
							digit_run = 1;
							digit_any = 0;
							digit_ovf = 0;
							value_byte(ch);
						end
					end
					hfp_pkg::PHC_VALUE: begin
						if (ch == hfp_pkg::CH_LF && recent[0] == hfp_pkg::CH_CR) begin
							vsize = pos - voff - 16'd1;
							ph = hfp_pkg::PHC_VEND;
						end else begin
							value_byte(ch);
						end
					end
					hfp_pkg::PHC_VEND: begin
						if (host_ok) begin
							host_seen = 1;
							host_start = voff;
							host_len = vsize;
						end else if (clen_ok) begin
							if (digit_any && !digit_ovf) begin
								clen_seen = 1;
								clen_value = digits;
							end else begin
								clen_err = 1;
							end
						end
						ph = hfp_pkg::PHC_KEY;
						key_restart();
						key_byte(ch);
					end
					default: ;
				endcase
				if (ch == hfp_pkg::CH_LF && recent[0] == hfp_pkg::CH_CR
					&& recent[1] == hfp_pkg::CH_LF && recent[2] == hfp_pkg::CH_CR)
					ph = hfp_pkg::PHC_END;
				recent[2] = recent[1];
				recent[1] = recent[0];
				recent[0] = ch;
			end
			want.phase = ph;
			want.host_seen = host_seen;
			want.host_start = host_start;
			want.host_length = host_len;
			want.length_seen = clen_seen;
			want.body_length = clen_value;
			want.length_error = clen_err;
			expected_states.push_back(want);
		endfunction

		function int pending();
			return expected_states.size();
		endfunction

		task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
			$display("%0t ns: mismatch on %s: got %0h, want %0h", $time, what, got, want);
			mismatches++;
		endtask

		task check_state(hfp_pkg::result_t got);
			hfp_pkg::result_t want;
			if (expected_states.size() == 0) begin
				report_mismatch("result item with nothing outstanding", got.phase, 0);
				return;
			end
			want = expected_states.pop_front();
			if (got.phase !== want.phase)
				report_mismatch("phase", got.phase, want.phase);
			if (got.host_seen !== want.host_seen)
				report_mismatch("host_seen", got.host_seen, want.host_seen);
			if (got.host_start !== want.host_start)
				report_mismatch("host_start", got.host_start, want.host_start);
			if (got.host_length !== want.host_length)
				report_mismatch("host_length", got.host_length, want.host_length);
			if (got.length_seen !== want.length_seen)
				report_mismatch("length_seen", got.length_seen, want.length_seen);
			if (got.body_length !== want.body_length)
				report_mismatch("body_length", got.body_length, want.body_length);
			if (got.length_error !== want.length_error)
				report_mismatch("length_error", got.length_error, want.length_error);
		endtask
	endclass

	bit clk;
	logic arst_n;
	hfp_in_if hdr_ch ();
	hfp_out_if res_ch ();
	header_tracker tracker = new();

	logic [hfp_pkg::POS_W-1:0] next_pos;
	logic [hfp_pkg::BYTE_W-1:0] sent_recent [3] = '{default: '0};
	bit allow_end = 0;
	int sent_count = 0;
	int fast_items = 0;
	int in_burst = 0;
	bit out_hold_req = 0;
	int idle_cycles = 0;

	http_header_field_parser_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.hdr    (hdr_ch),
		.res    (res_ch)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	task automatic send_byte(input logic [hfp_pkg::BYTE_W-1:0] b);
		int gap;
		if (fast_items > 0) begin
			gap = 0;
			fast_items--;
		end else if (in_burst > 0) begin
			gap = 0;
			in_burst--;
		end else begin
			gap = $urandom_range(0, 17);
			if ($urandom_range(0, 19) == 0)
				in_burst = 25;
		end
		if (gap > 0) begin
			hdr_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		hdr_ch.valid <= 1'b1;
		hdr_ch.byte_req <= b;
		hdr_ch.position <= next_pos;
		@(posedge clk);
		while (!hdr_ch.ready) @(posedge clk);
		tracker.note_byte(b, next_pos);
		next_pos++;
		sent_count++;
	endtask

	// A blank line would end parsing early, so it is broken up until the end.
	task automatic put_byte(input logic [hfp_pkg::BYTE_W-1:0] b);
		logic [hfp_pkg::BYTE_W-1:0] ch;
		ch = b;
		if (!allow_end && ch == hfp_pkg::CH_LF && sent_recent[0] == hfp_pkg::CH_CR
			&& sent_recent[1] == hfp_pkg::CH_LF && sent_recent[2] == hfp_pkg::CH_CR)
			ch = "x";
		sent_recent[2] = sent_recent[1];
		sent_recent[1] = sent_recent[0];
		sent_recent[0] = ch;
		send_byte(ch);
	endtask

	task automatic put_text(input string s);
		for (int i = 0; i < s.len(); i++)
			put_byte(s[i]);
	endtask

	task automatic put_crlf();
		put_byte(hfp_pkg::CH_CR);
		put_byte(hfp_pkg::CH_LF);
	endtask

	task automatic put_random_field();
		int kind;
		int n;
		logic [31:0] num;
		kind = $urandom_range(0, 10);
		if (kind <= 2) begin
			put_text(HOST_KEY);
		end else if (kind <= 6) begin
			put_text(CLEN_KEY);
		end else if (kind == 7) begin
			case ($urandom_range(0, 5))
				0: put_text("host");
				1: put_text("Hos");
				2: put_text("Hostt");
				3: put_text("Content-length");
				4: put_text("Content-Lengt");
				default: put_text("Content-Lengthh");
			endcase
		end else if (kind == 8) begin
			repeat ($urandom_range(0, 24)) put_byte(8'($urandom_range(8'h41, 8'h7A)));
		end else if (kind == 9) begin
			repeat ($urandom_range(1, 8)) put_byte(8'($urandom_range(0, 255)));
			put_crlf();
			return;
		end else begin
			put_text($urandom_range(0, 1) ? HOST_KEY : CLEN_KEY);
			put_crlf();
			return;
		end
		put_byte(hfp_pkg::CH_COLON);
		repeat ($urandom_range(0, 3)) put_byte(hfp_pkg::CH_SPACE);
		if (kind >= 3 && kind <= 6) begin
			case ($urandom_range(0, 7))
				0: ;
				1: put_text("abc");
				2: put_text("99999999999");
				3: put_text($urandom_range(0, 1) ? "4294967295" : "4294967296");
				4: put_text($sformatf("%0d%0s7", $urandom_range(0, 999),
					$urandom_range(0, 1) ? "x" : " "));
				5: put_text($sformatf("00%0d", $urandom_range(0, 99)));
				default: begin
					num = $urandom() >> $urandom_range(0, 31);
					put_text($sformatf("%0d", num));
				end
			endcase
		end else begin
			n = $urandom_range(0, 12);
			for (int i = 0; i < n; i++) begin
				if ($urandom_range(0, 4) == 0)
					put_byte(8'($urandom_range(0, 255)));
				else if ($urandom_range(0, 7) == 0)
					put_byte(hfp_pkg::CH_LF);
				else
					put_byte(8'($urandom_range(8'h21, 8'h7E)));
			end
		end
		put_crlf();
	endtask

	initial begin : byte_source
		bit held;
		bit drained;
		held = 0;
		drained = 0;
		arst_n <= 1'b0;
		hdr_ch.valid <= 1'b0;
		hdr_ch.byte_req <= '0;
		hdr_ch.position <= '0;
		next_pos = 16'hFFF0 + 16'($urandom_range(0, 4));
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty Host value, a key that starts with a colon, a bare LF inside a
		// value, both byte extremes and a wrap of the position.
		put_text("Host:");
		put_crlf();
		put_text(":: 7");
		put_byte(hfp_pkg::CH_LF);
		put_byte(8'h00);
		put_crlf();
		put_text("Host: ");
		put_byte(8'hFF);
		put_crlf();

		while (sent_count < RANDOM_ITEMS) begin
			put_random_field();
			if (!held && sent_count >= 200) begin
				held = 1;
				out_hold_req = 1;
				fast_items = 40;
			end
			if (!drained && sent_count >= 360) begin
				drained = 1;
				hdr_ch.valid <= 1'b0;
				do @(posedge clk); while (tracker.pending() != 0);
			end
		end
		allow_end = 1;
		put_crlf();
		put_crlf();
		repeat (6) put_byte(8'($urandom_range(0, 255)));
		hdr_ch.valid <= 1'b0;

		do @(posedge clk); while (tracker.pending() != 0);
		repeat (8) @(posedge clk);
		if (tracker.mismatches == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	initial begin : result_sink
		hfp_pkg::result_t got;
		int gap;
		int quiet;
		quiet = 0;
		res_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (quiet > 0) begin
				gap = 0;
				quiet--;
			end else begin
				gap = $urandom_range(0, 17);
				if ($urandom_range(0, 19) == 0)
					quiet = 30;
			end
			if (out_hold_req) begin
				out_hold_req = 0;
				gap += 60;
			end
			if (gap > 0) begin
				res_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			res_ch.ready <= 1'b1;
			@(posedge clk);
			while (!res_ch.valid) @(posedge clk);
			got.phase = res_ch.phase;
			got.host_seen = res_ch.host_seen;
			got.host_start = res_ch.host_start;
			got.host_length = res_ch.host_length;
			got.length_seen = res_ch.length_seen;
			got.body_length = res_ch.body_length;
			got.length_error = res_ch.length_error;
			tracker.check_state(got);
		end
	end

	always @(posedge clk) begin
		if ((hdr_ch.valid && hdr_ch.ready) || (res_ch.valid && res_ch.ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

endmodule
